// ===== hdl/ptc_pkg.sv =====
// shared constants for the pressure/temperature compensation pipeline
// used by the top level and by the constant divider, no dependencies
`default_nettype none
package ptc_pkg;

  // divisor of both polynomials, one less than a power of two
  localparam int DIV_SHIFT = 15;
  localparam int DIV_CONST = 32767;

  // configuration register indexes
  localparam logic [1:0] CFG_CAL_LO  = 2'd0;
  localparam logic [1:0] CFG_CAL_MID = 2'd1;
  localparam logic [1:0] CFG_CAL_HI  = 2'd2;
  localparam logic [1:0] CFG_CAL_B24 = 2'd3;

  // linear scaling of the sixteen-bit coefficients: gain * raw + offset
  localparam int A1_GAIN  = 3608;
  localparam int A1_OFS   = -1731677965;
  localparam int A2_GAIN  = 16889;
  localparam int A2_OFS   = -87619360;
  localparam int BT1_GAIN = 2982;
  localparam int BT1_OFS  = 107370906;
  localparam int BT2_GAIN = 329854;
  localparam int BT2_OFS  = 108083093;
  localparam int BP1_GAIN = 19923;
  localparam int BP1_OFS  = 1133836764;
  localparam int B11_GAIN = 2406;
  localparam int B11_OFS  = 118215883;
  localparam int BP2_GAIN = 3079;
  localparam int BP2_OFS  = -181579595;
  localparam int B12_GAIN = 6846;
  localparam int B12_OFS  = 85590281;
  localparam int B21_GAIN = 13836;
  localparam int B21_OFS  = 79333336;
  localparam int BP3_GAIN = 2915;
  localparam int BP3_OFS  = 157155561;

endpackage
`default_nettype wire

// ===== hdl/ptc_div.sv =====
// five-stage signed divide by 32767, truncating toward zero
// depends on ptc_pkg for the divisor
`default_nettype none
module ptc_div #(
  parameter int W = 64
) (
  input  wire logic                clk,
  input  wire logic signed [W-1:0] num,
  output logic signed [W-1:0]      quo
);

  // number of shifted terms in the reciprocal series
  localparam int K  = (W - 1) / ptc_pkg::DIV_SHIFT;
  localparam int RW = ptc_pkg::DIV_SHIFT + $clog2(K + 3);

  logic          neg1_r, neg2_r, neg3_r, neg4_r;
  logic [W-1:0]  mag1_r, mag2_r;
  logic [W-1:0]  acc2_r, q0_3_r;
  logic [RW-1:0] rem3_r;
  logic [W-1:0]  corr4_r;
  logic [W-1:0]  mag0_nxt;
  logic [W-1:0]  acc_nxt;
  logic [W-1:0]  corr_nxt;

  assign mag0_nxt = num[W-1] ? $unsigned(-num) : $unsigned(num);

  // floor sum of n / 2^(15k) is a slight underestimate of n / 32767
  always_comb begin
    acc_nxt = '0;
    for (int k = 1; k <= K; k++) begin
      acc_nxt = acc_nxt + (mag1_r >> (ptc_pkg::DIV_SHIFT * k));
    end
  end

  // remainder stays below (K + 1) * 32767, so a few compares finish it
  always_comb begin
    corr_nxt = q0_3_r;
    for (int j = 1; j <= K + 1; j++) begin
      if (rem3_r >= RW'(j * ptc_pkg::DIV_CONST)) begin
        corr_nxt = corr_nxt + W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    neg1_r  <= num[W-1];
    mag1_r  <= mag0_nxt;
    neg2_r  <= neg1_r;
    mag2_r  <= mag1_r;
    acc2_r  <= acc_nxt;
    neg3_r  <= neg2_r;
    q0_3_r  <= acc2_r;
    rem3_r  <= RW'(mag2_r - (acc2_r << ptc_pkg::DIV_SHIFT) + acc2_r);
    neg4_r  <= neg3_r;
    corr4_r <= corr_nxt;
    quo     <= neg4_r ? $signed(W'(0) - corr4_r) : $signed(corr4_r);
  end

endmodule
`default_nettype wire

// ===== hdl/pressure_temperature_compensation.sv =====
// top level of the pressure/temperature compensation pipeline
// depends on ptc_pkg and ptc_div
`default_nettype none
// usage
//   input: a beat of raw pressure and raw temperature is taken at each rising
//   edge with start high and busy low; busy stays low, so a beat may be given
//   in every cycle and the pipeline holds up to twenty-one beats at once
//   output: out_valid is high for exactly one cycle per beat, with the
//   compensated temperature and pressure beside it; the receiver cannot stall
//   throughput: one beat per cycle, set by the fully pipelined chain of
//   multipliers and the two pipelined dividers by 32767 (five stages each)
//   config: the four calibration registers are written through cfg_we,
//   cfg_index and cfg_data; the user must write them only while no beat is
//   in flight, the block does not enforce this; coefficients are rebuilt
//   into registers in the cycle after a write
//   reset: rst_n low clears all valid bits and the calibration registers
module pressure_temperature_compensation (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [23:0]        in_raw_pressure,
  input  wire logic [23:0]        in_raw_temperature,
  output logic                    out_valid,
  output logic signed [15:0]      out_comp_temperature,
  output logic signed [31:0]      out_comp_pressure,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [63:0]        cfg_data
);

  localparam int NV = 21;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // calibration storage
  logic [63:0] cal0_r, cal1_r, cal2_r;
  logic [7:0]  cal24_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal0_r  <= '0;
      cal1_r  <= '0;
      cal2_r  <= '0;
      cal24_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ptc_pkg::CFG_CAL_LO:  cal0_r  <= cfg_data;
        ptc_pkg::CFG_CAL_MID: cal1_r  <= cfg_data;
        ptc_pkg::CFG_CAL_HI:  cal2_r  <= cfg_data;
        ptc_pkg::CFG_CAL_B24: cal24_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  logic [199:0] cal_all;
  assign cal_all = {cal24_r, cal2_r, cal1_r, cal0_r};

  // raw sixteen-bit coefficients, high byte first
  logic signed [15:0] c20, c22, c2, c4, c6, c8, c10, c12, c14, c16;
  assign c20 = $signed({cal_all[20*8 +: 8], cal_all[21*8 +: 8]});
  assign c22 = $signed({cal_all[22*8 +: 8], cal_all[23*8 +: 8]});
  assign c2  = $signed({cal_all[2*8 +: 8],  cal_all[3*8 +: 8]});
  assign c4  = $signed({cal_all[4*8 +: 8],  cal_all[5*8 +: 8]});
  assign c6  = $signed({cal_all[6*8 +: 8],  cal_all[7*8 +: 8]});
  assign c8  = $signed({cal_all[8*8 +: 8],  cal_all[9*8 +: 8]});
  assign c10 = $signed({cal_all[10*8 +: 8], cal_all[11*8 +: 8]});
  assign c12 = $signed({cal_all[12*8 +: 8], cal_all[13*8 +: 8]});
  assign c14 = $signed({cal_all[14*8 +: 8], cal_all[15*8 +: 8]});
  assign c16 = $signed({cal_all[16*8 +: 8], cal_all[17*8 +: 8]});

  logic signed [19:0] a0_r, b00_r;
  logic signed [31:0] a1_r, a2_r, bt1_r, bp1_r, b11_r, bp2_r, b12_r, b21_r, bp3_r;
  logic signed [35:0] bt2_r;

  always_ff @(posedge clk) begin
    a0_r  <= $signed({cal_all[18*8 +: 8], cal_all[19*8 +: 8], cal24_r[3:0]});
    b00_r <= $signed({cal_all[7:0], cal_all[15:8], cal24_r[7:4]});
    a1_r  <= 32'(40'(c20) * 40'(ptc_pkg::A1_GAIN)  + 40'(ptc_pkg::A1_OFS));
    a2_r  <= 32'(40'(c22) * 40'(ptc_pkg::A2_GAIN)  + 40'(ptc_pkg::A2_OFS));
    bt1_r <= 32'(40'(c2)  * 40'(ptc_pkg::BT1_GAIN) + 40'(ptc_pkg::BT1_OFS));
    bt2_r <= 36'(40'(c4)  * 40'(ptc_pkg::BT2_GAIN) + 40'(ptc_pkg::BT2_OFS));
    bp1_r <= 32'(40'(c6)  * 40'(ptc_pkg::BP1_GAIN) + 40'(ptc_pkg::BP1_OFS));
    b11_r <= 32'(40'(c8)  * 40'(ptc_pkg::B11_GAIN) + 40'(ptc_pkg::B11_OFS));
    bp2_r <= 32'(40'(c10) * 40'(ptc_pkg::BP2_GAIN) + 40'(ptc_pkg::BP2_OFS));
    b12_r <= 32'(40'(c12) * 40'(ptc_pkg::B12_GAIN) + 40'(ptc_pkg::B12_OFS));
    b21_r <= 32'(40'(c14) * 40'(ptc_pkg::B21_GAIN) + 40'(ptc_pkg::B21_OFS));
    bp3_r <= 32'(40'(c16) * 40'(ptc_pkg::BP3_GAIN) + 40'(ptc_pkg::BP3_OFS));
  end

  // valid bits travel with the beat
  logic [NV-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NV-2:0], accept};
    end
  end

  // stage 0: recentering by 2^23 is a flip of the top bit
  logic signed [23:0] dp_d_r [0:12];
  logic signed [23:0] dt0_r, dt1_r;

  always_ff @(posedge clk) begin
    dp_d_r[0] <= $signed({~in_raw_pressure[23], in_raw_pressure[22:0]});
    dt0_r     <= $signed({~in_raw_temperature[23], in_raw_temperature[22:0]});
    for (int i = 1; i <= 12; i++) begin
      dp_d_r[i] <= dp_d_r[i-1];
    end
  end

  // temperature polynomial
  logic signed [55:0] m1_r, m2_r, m1b_r;
  logic signed [63:0] w2b_r;
  logic signed [56:0] tsum_r;
  logic signed [56:0] q1;

  always_ff @(posedge clk) begin
    m1_r   <= a1_r * dt0_r;
    m2_r   <= a2_r * dt0_r;
    dt1_r  <= dt0_r;
    m1b_r  <= m1_r;
    w2b_r  <= ((m2_r >>> 14) * dt1_r) >>> 10;
    tsum_r <= 57'(w2b_r + 64'(m1b_r));
  end

  ptc_div #(.W(57)) u_div_t (
    .clk (clk),
    .num (tsum_r),
    .quo (q1)
  );

  // tsum at stage 3, quotient at stage 8, tx at stage 9
  logic signed [56:0] tt;
  assign tt = (q1 >>> 19) + 57'(a0_r);

  logic signed [15:0] tx_d_r [9:20];
  always_ff @(posedge clk) begin
    tx_d_r[9] <= 16'(tt >>> 4);
    for (int i = 10; i <= 20; i++) begin
      tx_d_r[i] <= tx_d_r[i-1];
    end
  end

  // pressure polynomial
  logic signed [47:0] w1a_r, v_r, y_r, z_r;
  logic signed [55:0] t1_r, x_r, s_r;
  logic signed [51:0] u_r;
  logic signed [63:0] w1b_r, w1c_r, w1d_r, w1e_r;
  logic signed [63:0] pa_r, pb_r, pc_r, pd_r, pe_r, pf_r;
  logic signed [63:0] pg_r, ph_r, pi_r, w3a_r, w3b_r;
  logic signed [63:0] q2;

  always_ff @(posedge clk) begin
    // first products, stage 10
    w1a_r <= bt1_r * tx_d_r[9];
    t1_r  <= bp1_r * dp_d_r[9];
    u_r   <= bt2_r * tx_d_r[9];
    v_r   <= b11_r * tx_d_r[9];
    x_r   <= bp2_r * dp_d_r[9];
    y_r   <= b12_r * tx_d_r[9];
    z_r   <= b21_r * tx_d_r[9];
    s_r   <= bp3_r * dp_d_r[9];
    // second products, stage 11
    w1b_r <= 64'(w1a_r) + 64'(t1_r >>> 5);
    pa_r  <= (64'(u_r) >>> 1) * tx_d_r[10];
    pb_r  <= (64'(v_r) >>> 4) * dp_d_r[10];
    pc_r  <= (64'(x_r) >>> 13) * dp_d_r[10];
    pd_r  <= 64'(y_r) * tx_d_r[10];
    pe_r  <= (64'(z_r) >>> 6) * dp_d_r[10];
    pf_r  <= (64'(s_r) >>> 12) * dp_d_r[10];
    // third products, stage 12
    w1c_r <= w1b_r;
    w3a_r <= (pa_r >>> 8) + (pb_r >>> 1) + (pc_r >>> 1);
    pg_r  <= (pd_r >>> 22) * dp_d_r[11];
    ph_r  <= (pe_r >>> 23) * dp_d_r[11];
    pi_r  <= (pf_r >>> 23) * dp_d_r[11];
    // accumulate, stages 13 and 14
    w1d_r <= w1c_r + (w3a_r >>> 14);
    w3b_r <= (pg_r >>> 1) + (ph_r >>> 1) + pi_r;
    w1e_r <= w1d_r + (w3b_r >>> 15);
  end

  ptc_div #(.W(64)) u_div_p (
    .clk (clk),
    .num (w1e_r),
    .quo (q2)
  );

  logic unused_dp;
  assign unused_dp = ^dp_d_r[12];

  // quotient at stage 19, result registers at stage 20
  always_ff @(posedge clk) begin
    out_comp_pressure    <= 32'((q2 >>> 11) + 64'(b00_r));
    out_comp_temperature <= tx_d_r[19];
  end

  assign out_valid = vld_r[NV-1];

  logic unused_tx;
  assign unused_tx = ^tx_d_r[20];

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##21 out_valid)
    else $error("result strobe missing");

  a_temp_path: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_comp_temperature == $past(tx_d_r[9], 11))
    else $error("temperature out of step with pressure");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("strobe after reset");

endmodule
`default_nettype wire

// ===== bench/pressure_temperature_compensation_tb.sv =====
// testbench for the pressure/temperature compensation pipeline
// predicts each beat with a 64-bit integer model of the polynomials; needs ptc_pkg
module pressure_temperature_compensation_tb;

  localparam int LATENCY = 20;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [23:0] in_raw_pressure = '0;
  logic [23:0] in_raw_temperature = '0;
  logic out_valid;
  logic signed [15:0] out_comp_temperature;
  logic signed [31:0] out_comp_pressure;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  pressure_temperature_compensation dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_raw_pressure(in_raw_pressure), .in_raw_temperature(in_raw_temperature),
    .out_valid(out_valid), .out_comp_temperature(out_comp_temperature),
    .out_comp_pressure(out_comp_pressure),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  typedef struct packed {
    logic signed [15:0] temp;
    logic signed [31:0] pres;
  } comp_t;

  logic [63:0] cal_regs [4];
  comp_t comp_queue [$];
  int mismatches = 0;
  int beats_sent = 0;
  int beats_checked = 0;
  int cfg_writes = 0;
  longint cycles = 0;

  function automatic logic [7:0] cal_b(int k);
    return cal_regs[k >> 3][(k & 7) * 8 +: 8];
  endfunction

  function automatic longint c16(int hi);
    logic signed [15:0] v;
    v = {cal_b(hi), cal_b(hi + 1)};
    return longint'(v);
  endfunction

  // c-style division, truncating toward zero
  function automatic longint div_trunc(longint a);
    longint q;
    q = (a < 0) ? -((-a) / ptc_pkg::DIV_CONST) : a / ptc_pkg::DIV_CONST;
    return q;
  endfunction

  function automatic comp_t compensate(logic [23:0] rp, logic [23:0] rt);
    longint dp, dt, a0, b00, a1, a2, bt1, bt2, bp1, b11, bp2, b12, b21, bp3;
    longint w1, w2, w3, tx;
    logic signed [19:0] s20;
    logic signed [15:0] s16;
    logic [7:0] b24;
    comp_t r;
    dp = longint'(rp) - 64'sd8388608;
    dt = longint'(rt) - 64'sd8388608;
    b24 = cal_b(24);
    s20 = {cal_b(18), cal_b(19), b24[3:0]};
    a0 = s20;
    s20 = {cal_b(0), cal_b(1), b24[7:4]};
    b00 = s20;
    a1 = ptc_pkg::A1_GAIN * c16(20) + ptc_pkg::A1_OFS;
    a2 = ptc_pkg::A2_GAIN * c16(22) + ptc_pkg::A2_OFS;
    bt1 = ptc_pkg::BT1_GAIN * c16(2) + ptc_pkg::BT1_OFS;
    bt2 = ptc_pkg::BT2_GAIN * c16(4) + ptc_pkg::BT2_OFS;
    bp1 = ptc_pkg::BP1_GAIN * c16(6) + ptc_pkg::BP1_OFS;
    b11 = ptc_pkg::B11_GAIN * c16(8) + ptc_pkg::B11_OFS;
    bp2 = ptc_pkg::BP2_GAIN * c16(10) + ptc_pkg::BP2_OFS;
    b12 = ptc_pkg::B12_GAIN * c16(12) + ptc_pkg::B12_OFS;
    b21 = ptc_pkg::B21_GAIN * c16(14) + ptc_pkg::B21_OFS;
    bp3 = ptc_pkg::BP3_GAIN * c16(16) + ptc_pkg::BP3_OFS;
    w1 = a1 * dt;
    w2 = (a2 * dt) >>> 14;
    w2 = (w2 * dt) >>> 10;
    w2 = div_trunc(w1 + w2) >>> 19;
    s16 = 16'((a0 + w2) >>> 4);
    tx = s16;
    w1 = bt1 * tx;
    w1 += (bp1 * dp) >>> 5;
    w2 = (bt2 * tx) >>> 1;
    w3 = (w2 * tx) >>> 8;
    w2 = (b11 * tx) >>> 4;
    w3 += (w2 * dp) >>> 1;
    w2 = (bp2 * dp) >>> 13;
    w3 += (w2 * dp) >>> 1;
    w1 += w3 >>> 14;
    w2 = b12 * tx;
    w2 = (w2 * tx) >>> 22;
    w3 = (w2 * dp) >>> 1;
    w2 = (b21 * tx) >>> 6;
    w2 = (w2 * dp) >>> 23;
    w3 += (w2 * dp) >>> 1;
    w2 = (bp3 * dp) >>> 12;
    w2 = (w2 * dp) >>> 23;
    w3 += w2 * dp;
    w1 += w3 >>> 15;
    w1 = div_trunc(w1);
    w1 = w1 >>> 11;
    w1 += b00;
    r.temp = s16;
    r.pres = 32'(w1);
    return r;
  endfunction

  // result checker, sampled at the rising edge
  always @(posedge clk) begin
    comp_t want;
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      if (comp_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat t=%0d p=%0d",
                                       out_comp_temperature, out_comp_pressure);
      end else begin
        want = comp_queue.pop_front();
        beats_checked++;
        if (want.temp !== out_comp_temperature || want.pres !== out_comp_pressure) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: temp exp %0d got %0d, pres exp %0d got %0d",
                     want.temp, out_comp_temperature, want.pres, out_comp_pressure);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL pressure_temperature_compensation");
      $finish;
    end
  end

  int burst_left = 0;

  // start stays high after the beat so bursts run back to back
  task automatic send_beat(logic [23:0] rp, logic [23:0] rt, bit gaps);
    int gap;
    if (gaps) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          start <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst_left = $urandom_range(1, 30);
      end
      burst_left--;
    end
    start <= 1'b1;
    in_raw_pressure <= rp;
    in_raw_temperature <= rt;
    @(posedge clk);
    while (busy) @(posedge clk);
    comp_queue.push_back(compensate(rp, rt));
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (comp_queue.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_cal(logic [1:0] idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cal_regs[idx] = (idx == ptc_pkg::CFG_CAL_B24) ? {56'd0, val[7:0]} : val;
    cfg_writes++;
  endtask

  task automatic load_cal(logic [63:0] lo, logic [63:0] mid, logic [63:0] hi,
                          logic [63:0] b24);
    drain();
    write_cal(ptc_pkg::CFG_CAL_LO, lo);
    write_cal(ptc_pkg::CFG_CAL_MID, mid);
    write_cal(ptc_pkg::CFG_CAL_HI, hi);
    write_cal(ptc_pkg::CFG_CAL_B24, b24);
    cfg_we <= 1'b0;
    repeat (2) @(negedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic test_reset_cal();
    send_beat(24'h000000, 24'h000000, 0);
    send_beat(24'hFFFFFF, 24'hFFFFFF, 0);
    send_beat(24'h800000, 24'h800000, 0);
  endtask

  task automatic test_extremes();
    logic [63:0] pats [4];
    pats = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8080_8080_8080_8080,
             64'h7F7F_7F7F_7F7F_7F7F};
    foreach (pats[i]) begin
      load_cal(pats[i], pats[i], pats[i], pats[i]);
      send_beat(24'h000000, 24'h000000, 0);
      send_beat(24'hFFFFFF, 24'h000000, 0);
      send_beat(24'h000000, 24'hFFFFFF, 0);
      send_beat(24'hFFFFFF, 24'hFFFFFF, 0);
      send_beat(24'h7FFFFF, 24'h800000, 0);
    end
  endtask

  // temperature wrap: sweep raw temperature under large a1 and a2, small a0
  task automatic test_temp_wrap();
    load_cal(64'h0, 64'h0, 64'h7F7F_7FFF_0000_0000, 64'h0F);
    for (int i = 0; i < 4; i++)
      send_beat(24'($urandom()), 24'(i * 24'h3FFFFF + $urandom_range(0, 255)), 0);
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 8; phase++) begin
      load_cal(rand64(), rand64(), rand64(), rand64());
      for (int i = 0; i < 250; i++)
        send_beat(24'($urandom()), 24'($urandom()), 1);
    end
  endtask

  initial begin
    foreach (cal_regs[i]) cal_regs[i] = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_cal();
    test_extremes();
    test_temp_wrap();
    test_random();
    drain();
    $display("sent %0d beats over %0d register writes, checked %0d results",
             beats_sent, cfg_writes, beats_checked);
    if (mismatches == 0 && comp_queue.size() == 0) begin
      $display("PASS pressure_temperature_compensation");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL pressure_temperature_compensation");
    end
    $finish;
  end

endmodule
